// ----- rtl/swss_pkg.sv -----
`timescale 1ns / 1ps

package swss_pkg;

  // Default sizes of the sample ring and of a timestamp.
  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned TIME_BITS_DEF = 48;

  // Fixed field and register widths.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DRAW_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned WENT_W  = 7;
  localparam int unsigned WTIME_W = 40;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PROD_W  = DRAW_W + CNT_W;

  // Item kinds carried in the input tuser.
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SNAPSHOT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_WINDOW_ENTRIES = 2'd0;
  localparam logic [1:0] REG_WINDOW_TIME    = 2'd1;
  localparam logic [1:0] REG_SLICE_TIME     = 2'd2;

  // Register reset values.
  localparam logic [WENT_W-1:0]  WINDOW_ENTRIES_RST = 7'd64;
  localparam logic [WTIME_W-1:0] WINDOW_TIME_RST    = 40'd60000000;
  localparam logic [WTIME_W-1:0] SLICE_TIME_RST     = 40'd937500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPD_SLICE,
    ST_EXP_CHK,
    ST_EXP_RD,
    ST_DECIDE,
    ST_MUL,
    ST_REPL,
    ST_TRIM,
    ST_RESP,
    ST_SNAP_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic trd_newest;
    logic trd_oldest;
    logic slice_chk;
    logic pop;
    logic count_inc;
    logic mul;
    logic replace;
    logic append;
    logic trim;
    logic clear;
    logic snap_first;
    logic snap_next;
    logic out_load;
    logic out_snap;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              occ_zero;
    logic              occ_one;
    logic              beyond_win;
    logic              in_slice;
    logic              snap_last;
    logic              out_free;
  } status_t;

endpackage

// ----- rtl/sliding_window_slice_sampler.sv -----
`timescale 1ns / 1ps

// Items are captured, then decoded; clear and unused kinds go to the result. An update to
// a non-empty ring reads the newest timestamp for the slice test, then pops expired oldest
// entries, reading the timestamp store once per entry, then replaces or appends and trims.
// Snapshot: one value per cycle while the receiver takes it; one item at a time, the next
// taken the cycle after the last result is loaded. Reset is asynchronous and clears the
// ring pointers, counter and handshakes; stores are not cleared, registers take defaults.
module sliding_window_slice_sampler #(
  parameter int unsigned DEPTH     = swss_pkg::DEPTH_DEF,
  parameter int unsigned TIME_BITS = swss_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [swss_pkg::PADDR_W-1:0]          paddr,
  input  logic [swss_pkg::CFG_W-1:0]            pwdata,
  output logic [swss_pkg::CFG_W-1:0]            prdata,
  output logic                                  pready,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample_value, timestamp_us, random_draw, zero fill
  input  logic [((swss_pkg::VALUE_W + TIME_BITS + swss_pkg::DRAW_W + 7) / 8) * 8 - 1:0]
                                                s_axis_tdata,
  // mode
  input  logic [swss_pkg::MODE_W-1:0]           s_axis_tuser,
  // Output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_value, entry_count, zero fill
  output logic [((swss_pkg::VALUE_W + swss_pkg::COUNT_W + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,
  // has_value
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int unsigned OUT_W = ((swss_pkg::VALUE_W + swss_pkg::COUNT_W + 7) / 8) * 8;

  swss_pkg::cmd_t               cmd;
  swss_pkg::status_t            status;
  logic [swss_pkg::VALUE_W-1:0] out_value;
  logic [swss_pkg::COUNT_W-1:0] entry_count;

  assign pready = 1'b1;

  swss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  swss_dp #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mode_i         (s_axis_tuser),
    .sample_value_i (s_axis_tdata[swss_pkg::VALUE_W-1:0]),
    .timestamp_us_i (s_axis_tdata[swss_pkg::VALUE_W +: TIME_BITS]),
    .random_draw_i  (s_axis_tdata[swss_pkg::VALUE_W + TIME_BITS +: swss_pkg::DRAW_W]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_value_o    (out_value),
    .entry_count_o  (entry_count),
    .has_value_o    (m_axis_tuser),
    .last_o         (m_axis_tlast),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  assign m_axis_tdata = OUT_W'({entry_count, out_value});

endmodule

// ----- rtl/swss_ram.sv -----
`timescale 1ns / 1ps

module swss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/swss_ctrl.sv -----
`timescale 1ns / 1ps

module swss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  swss_pkg::status_t status_i,
  output swss_pkg::cmd_t   cmd_o
);

  swss_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      swss_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = swss_pkg::ST_DECODE;
        end
      end
      swss_pkg::ST_DECODE: begin
        unique case (status_i.mode)
          swss_pkg::MODE_UPDATE: begin
            if (status_i.occ_zero) begin
              state_d = swss_pkg::ST_DECIDE;
            end else begin
              cmd_o.trd_newest = 1'b1;
              state_d          = swss_pkg::ST_UPD_SLICE;
            end
          end
          swss_pkg::MODE_SNAPSHOT: begin
            if (status_i.occ_zero) begin
              state_d = swss_pkg::ST_RESP;
            end else begin
              cmd_o.snap_first = 1'b1;
              state_d          = swss_pkg::ST_SNAP_OUT;
            end
          end
          swss_pkg::MODE_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = swss_pkg::ST_RESP;
          end
          default: begin
            state_d = swss_pkg::ST_RESP;
          end
        endcase
      end
      // Newest timestamp is ready: settle the slice test, fetch the oldest.
      swss_pkg::ST_UPD_SLICE: begin
        cmd_o.slice_chk  = 1'b1;
        cmd_o.trd_oldest = 1'b1;
        state_d          = swss_pkg::ST_EXP_CHK;
      end
      // Oldest timestamp is ready: drop it if it has expired.
      swss_pkg::ST_EXP_CHK: begin
        if (status_i.beyond_win) begin
          cmd_o.pop = 1'b1;
          if (status_i.occ_one) begin
            state_d = swss_pkg::ST_DECIDE;
          end else begin
            state_d = swss_pkg::ST_EXP_RD;
          end
        end else begin
          state_d = swss_pkg::ST_DECIDE;
        end
      end
      swss_pkg::ST_EXP_RD: begin
        cmd_o.trd_oldest = 1'b1;
        state_d          = swss_pkg::ST_EXP_CHK;
      end
      swss_pkg::ST_DECIDE: begin
        if (!status_i.occ_zero && status_i.in_slice) begin
          cmd_o.count_inc = 1'b1;
          state_d         = swss_pkg::ST_MUL;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = swss_pkg::ST_TRIM;
        end
      end
      swss_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = swss_pkg::ST_REPL;
      end
      swss_pkg::ST_REPL: begin
        cmd_o.replace = 1'b1;
        state_d       = swss_pkg::ST_RESP;
      end
      swss_pkg::ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d    = swss_pkg::ST_RESP;
      end
      swss_pkg::ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = swss_pkg::ST_IDLE;
        end
      end
      // One stored value per transfer; the next read is issued as one leaves.
      swss_pkg::ST_SNAP_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_snap = 1'b1;
          if (status_i.snap_last) begin
            state_d = swss_pkg::ST_IDLE;
          end else begin
            cmd_o.snap_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = swss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/swss_dp.sv -----
`timescale 1ns / 1ps

module swss_dp #(
  parameter int unsigned DEPTH     = swss_pkg::DEPTH_DEF,
  parameter int unsigned TIME_BITS = swss_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swss_pkg::PADDR_W-1:0]  paddr,
  input  logic [swss_pkg::CFG_W-1:0]    pwdata,
  output logic [swss_pkg::CFG_W-1:0]    prdata,
  // Input item fields
  input  logic [swss_pkg::MODE_W-1:0]   mode_i,
  input  logic [swss_pkg::VALUE_W-1:0]  sample_value_i,
  input  logic [TIME_BITS-1:0]          timestamp_us_i,
  input  logic [swss_pkg::DRAW_W-1:0]   random_draw_i,
  // Result register
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [swss_pkg::VALUE_W-1:0]  out_value_o,
  output logic [swss_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                          has_value_o,
  output logic                          last_o,
  // Controller link
  input  swss_pkg::cmd_t                cmd_i,
  output swss_pkg::status_t             status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = OCC_W + 1;
  localparam int unsigned CMP_W =
    ((TIME_BITS > swss_pkg::WTIME_W) ? TIME_BITS : swss_pkg::WTIME_W) + 1;

  // Ring slot of an offset from a base pointer.
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
                                                 input logic [OCC_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [swss_pkg::WENT_W-1:0]  went_q;
  logic [swss_pkg::WTIME_W-1:0] wtime_q;
  logic [swss_pkg::WTIME_W-1:0] stime_q;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  logic [swss_pkg::MODE_W-1:0]  mode_q;
  logic [swss_pkg::VALUE_W-1:0] value_q;
  logic [TIME_BITS-1:0]         ts_q;
  logic [swss_pkg::DRAW_W-1:0]  draw_q;

  logic [PTR_W-1:0]             ptr_q, ptr_d;
  logic [OCC_W-1:0]             occ_q, occ_d;
  logic [swss_pkg::CNT_W-1:0]   cnt_q;
  logic [OCC_W-1:0]             k_q;
  logic                         slice_beyond_q;
  logic [swss_pkg::PROD_W-1:0]  prod_q;

  logic                         out_valid_q;
  logic [swss_pkg::VALUE_W-1:0] out_value_q;
  logic [swss_pkg::COUNT_W-1:0] out_count_q;
  logic                         out_has_q;
  logic                         out_last_q;

  logic [PTR_W-1:0]             newest_slot;
  logic [PTR_W-1:0]             tail_slot;
  logic [OCC_W-1:0]             cap;
  logic                         snap_last;
  logic                         out_free;

  logic                         vram_we;
  logic [PTR_W-1:0]             vram_waddr;
  logic                         vram_re;
  logic [PTR_W-1:0]             vram_raddr;
  logic [swss_pkg::VALUE_W-1:0] vram_rdata;
  logic                         tram_re;
  logic [PTR_W-1:0]             tram_raddr;
  logic [TIME_BITS-1:0]         tram_rdata;

  logic [CMP_W-1:0]             win_lim;
  logic [CMP_W-1:0]             slice_lim;
  logic                         beyond_win;
  logic                         beyond_slice;

  // Configuration registers; the register index sits above the 8-byte offset.
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[swss_pkg::PADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      went_q  <= swss_pkg::WINDOW_ENTRIES_RST;
      wtime_q <= swss_pkg::WINDOW_TIME_RST;
      stime_q <= swss_pkg::SLICE_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        swss_pkg::REG_WINDOW_ENTRIES: went_q  <= pwdata[swss_pkg::WENT_W-1:0];
        swss_pkg::REG_WINDOW_TIME:    wtime_q <= pwdata[swss_pkg::WTIME_W-1:0];
        swss_pkg::REG_SLICE_TIME:     stime_q <= pwdata[swss_pkg::WTIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      swss_pkg::REG_WINDOW_ENTRIES: prdata = swss_pkg::CFG_W'(went_q);
      swss_pkg::REG_WINDOW_TIME:    prdata = swss_pkg::CFG_W'(wtime_q);
      swss_pkg::REG_SLICE_TIME:     prdata = swss_pkg::CFG_W'(stime_q);
      default:                      prdata = '0;
    endcase
  end

  // Item holding register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      value_q <= sample_value_i;
      ts_q    <= timestamp_us_i;
      draw_q  <= random_draw_i;
    end
  end

  // Ring addressing.
  assign newest_slot = wrap_slot(ptr_q, occ_q - OCC_W'(1));
  assign tail_slot   = wrap_slot(ptr_q, occ_q);
  assign cap         = (went_q > swss_pkg::WENT_W'(DEPTH)) ? OCC_W'(DEPTH)
                                                           : went_q[OCC_W-1:0];
  assign snap_last   = (k_q + OCC_W'(1)) == occ_q;

  // Expiry and slice tests against the timestamp just read.
  assign win_lim      = CMP_W'(tram_rdata) + CMP_W'(wtime_q);
  assign slice_lim    = CMP_W'(tram_rdata) + CMP_W'(stime_q);
  assign beyond_win   = CMP_W'(ts_q) > win_lim;
  assign beyond_slice = CMP_W'(ts_q) > slice_lim;

  // Oldest pointer and occupancy.
  always_comb begin
    ptr_d = ptr_q;
    occ_d = occ_q;
    priority if (cmd_i.clear) begin
      ptr_d = '0;
      occ_d = '0;
    end else if (cmd_i.pop) begin
      ptr_d = wrap_slot(ptr_q, OCC_W'(1));
      occ_d = occ_q - OCC_W'(1);
    end else if (cmd_i.append) begin
      if (occ_q == OCC_W'(DEPTH)) begin
        ptr_d = wrap_slot(ptr_q, OCC_W'(1));
      end else begin
        occ_d = occ_q + OCC_W'(1);
      end
    end else if (cmd_i.trim) begin
      if (occ_q > cap) begin
        ptr_d = wrap_slot(ptr_q, occ_q - cap);
        occ_d = cap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      occ_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      occ_q <= occ_d;
    end
  end

  // Slice counter, saturating.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      slice_beyond_q <= 1'b0;
    end else begin
      if (cmd_i.slice_chk) begin
        slice_beyond_q <= beyond_slice;
      end
      priority if (cmd_i.slice_chk && beyond_slice) begin
        cnt_q <= '0;
      end else if (cmd_i.count_inc) begin
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + swss_pkg::CNT_W'(1);
        end
      end else if (cmd_i.append) begin
        cnt_q <= swss_pkg::CNT_W'(1);
      end
    end
  end

  // Replacement product and snapshot index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= swss_pkg::PROD_W'(draw_q) * swss_pkg::PROD_W'(cnt_q);
    end
    if (cmd_i.snap_first) begin
      k_q <= '0;
    end else if (cmd_i.snap_next) begin
      k_q <= k_q + OCC_W'(1);
    end
  end

  // Store ports.
  assign vram_we    = cmd_i.append ||
                      (cmd_i.replace && (prod_q[swss_pkg::PROD_W-1:swss_pkg::CNT_W] == '0));
  assign vram_waddr = cmd_i.replace ? newest_slot : tail_slot;
  assign vram_re    = cmd_i.snap_first || cmd_i.snap_next;
  assign vram_raddr = cmd_i.snap_first ? ptr_q : wrap_slot(ptr_q, k_q + OCC_W'(1));
  assign tram_re    = cmd_i.trd_newest || cmd_i.trd_oldest;
  assign tram_raddr = cmd_i.trd_newest ? newest_slot : ptr_q;

  swss_ram #(
    .WIDTH (swss_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (value_q),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  swss_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (tail_slot),
    .wdata_i (ts_q),
    .re_i    (tram_re),
    .raddr_i (tram_raddr),
    .rdata_o (tram_rdata)
  );

  // Result register; it frees as soon as the waiting transfer completes.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= cmd_i.out_snap ? vram_rdata : '0;
      out_count_q <= swss_pkg::COUNT_W'(occ_q);
      out_has_q   <= cmd_i.out_snap;
      out_last_q  <= cmd_i.out_snap ? snap_last : 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign entry_count_o = out_count_q;
  assign has_value_o   = out_has_q;
  assign last_o        = out_last_q;

  // Status back to the controller.
  assign status_o.mode       = mode_q;
  assign status_o.occ_zero   = occ_q == '0;
  assign status_o.occ_one    = occ_q == OCC_W'(1);
  assign status_o.beyond_win = beyond_win;
  assign status_o.in_slice   = !slice_beyond_q;
  assign status_o.snap_last  = snap_last;
  assign status_o.out_free   = out_free;

endmodule

// ----- dv/swss_checker.sv -----
`timescale 1ns / 1ps

module window_sample_checker #(
  parameter int unsigned IN_W  = 144,
  parameter int unsigned OUT_W = 72
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port, watched only
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swss_pkg::PADDR_W-1:0]  paddr,
  input  logic [swss_pkg::CFG_W-1:0]    pwdata,
  input  logic                          pready,
  // Input stream, watched only
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // sample_value, timestamp_us, random_draw
  input  logic [IN_W-1:0]               s_axis_tdata,
  // mode
  input  logic [swss_pkg::MODE_W-1:0]   s_axis_tuser,
  // Output stream, watched only
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_value, entry_count, zero fill
  input  logic [OUT_W-1:0]              m_axis_tdata,
  // has_value
  input  logic                          m_axis_tuser,
  input  logic                          m_axis_tlast,
  // Verdict inputs for the top
  output int                            mismatch_count_o,
  output int                            pending_results_o,
  output int                            results_checked_o
);
  import swss_pkg::*;

  localparam int unsigned        RING         = DEPTH_DEF;
  localparam int unsigned        TW           = TIME_BITS_DEF;
  localparam logic [CNT_W-1:0]   COUNT_MAX    = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] entries;
    logic               has_value;
    logic               last;
  } window_result_t;

  // Own copy of the sample ring, the slice counter and the registers.
  logic [VALUE_W-1:0] value_ring [RING];
  logic [TW-1:0]      stamp_ring [RING];
  int unsigned        oldest;
  int unsigned        occupied;
  logic [CNT_W-1:0]   slice_count;
  logic [WENT_W-1:0]  cfg_entries;
  logic [WTIME_W-1:0] cfg_window;
  logic [WTIME_W-1:0] cfg_slice;

  window_result_t expected_results [$];
  window_result_t got;
  window_result_t want;
  int             mismatches;
  int             checked;

  function automatic int unsigned ring_slot(input int unsigned k);
    return (oldest + k) % RING;
  endfunction

  // True when t lies strictly after base + span; no wrap is possible.
  function automatic logic later_than(input logic [TW-1:0] t, input logic [TW-1:0] base,
                                      input logic [WTIME_W-1:0] span);
    return (t > base) && ((t - base) > span);
  endfunction

  task automatic drop_oldest();
    if (occupied != 0) begin
      oldest   = (oldest + 1) % RING;
      occupied = occupied - 1;
    end
  endtask

  task automatic predict_update(input logic [VALUE_W-1:0] value, input logic [TW-1:0] ts,
                                input logic [DRAW_W-1:0] draw);
    int unsigned       cap;
    logic [PROD_W-1:0] product;
    cap = (cfg_entries > RING) ? RING : cfg_entries;
    // A new slice restarts the counter; expired samples leave from the old end.
    if (occupied > 0) begin
      if (later_than(ts, stamp_ring[ring_slot(occupied - 1)], cfg_slice))
        slice_count = '0;
      while (occupied > 0 && later_than(ts, stamp_ring[oldest], cfg_window))
        drop_oldest();
    end
    if (occupied > 0 && !later_than(ts, stamp_ring[ring_slot(occupied - 1)], cfg_slice)) begin
      // Same slice: keep one sample of the slice by reservoir replacement.
      if (slice_count != COUNT_MAX)
        slice_count = slice_count + 1'b1;
      product = {{(PROD_W - DRAW_W){1'b0}}, draw} * {{(PROD_W - CNT_W){1'b0}}, slice_count};
      if (product <= {{(PROD_W - CNT_W){1'b0}}, COUNT_MAX})
        value_ring[ring_slot(occupied - 1)] = value;
    end else begin
      if (occupied >= RING)
        drop_oldest();
      value_ring[ring_slot(occupied)] = value;
      stamp_ring[ring_slot(occupied)] = ts;
      occupied    = occupied + 1;
      slice_count = 1;
      while (occupied > cap)
        drop_oldest();
    end
  endtask

  // Work out every result that one accepted input transfer causes.
  task automatic predict_item(input logic [MODE_W-1:0] mode, input logic [IN_W-1:0] data);
    int unsigned k;
    case (mode)
      MODE_UPDATE: begin
        predict_update(data[VALUE_W-1:0], data[VALUE_W +: TW], data[VALUE_W + TW +: DRAW_W]);
      end
      MODE_CLEAR: begin
        oldest   = 0;
        occupied = 0;
      end
      default: begin
      end
    endcase
    if (mode == MODE_SNAPSHOT && occupied > 0) begin
      for (k = 0; k < occupied; k++)
        expected_results.push_back('{value: value_ring[ring_slot(k)],
                                     entries: COUNT_W'(occupied),
                                     has_value: 1'b1, last: (k + 1 == occupied)});
    end else begin
      expected_results.push_back('{value: '0, entries: COUNT_W'(occupied),
                                   has_value: 1'b0, last: 1'b1});
    end
  endtask

  task automatic report_field(input string field, input logic [VALUE_W-1:0] expected_val,
                              input logic [VALUE_W-1:0] actual_val);
    mismatches++;
    $display("%0t ns: result %0d, %s expected 0x%0h actual 0x%0h",
             $time, checked, field, expected_val, actual_val);
  endtask

  // Watch all three ports at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest      = 0;
      occupied    = 0;
      slice_count = '0;
      cfg_entries = WINDOW_ENTRIES_RST;
      cfg_window  = WINDOW_TIME_RST;
      cfg_slice   = SLICE_TIME_RST;
      expected_results.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_WINDOW_ENTRIES: cfg_entries = pwdata[WENT_W-1:0];
          REG_WINDOW_TIME:    cfg_window  = pwdata[WTIME_W-1:0];
          REG_SLICE_TIME:     cfg_slice   = pwdata[WTIME_W-1:0];
          default: begin
          end
        endcase
      end

      // Result transfers against the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{value: m_axis_tdata[VALUE_W-1:0], entries: m_axis_tdata[VALUE_W +: COUNT_W],
                has_value: m_axis_tuser, last: m_axis_tlast};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none actual value 0x%0h count %0d",
                   $time, got.value, got.entries);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.value !== want.value)
            report_field("out_value", want.value, got.value);
          if (got.entries !== want.entries)
            report_field("entry_count", VALUE_W'(want.entries), VALUE_W'(got.entries));
          if (got.has_value !== want.has_value)
            report_field("has_value", VALUE_W'(want.has_value), VALUE_W'(got.has_value));
          if (got.last !== want.last)
            report_field("last", VALUE_W'(want.last), VALUE_W'(got.last));
        end
        checked++;
      end

      // Input transfers.
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata);
    end
    mismatch_count_o  <= mismatches;
    pending_results_o <= expected_results.size();
    results_checked_o <= checked;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import swss_pkg::*;

  localparam int unsigned        IN_W          = ((VALUE_W + TIME_BITS_DEF + DRAW_W + 7) / 8) * 8;
  localparam int unsigned        OUT_W         = ((VALUE_W + COUNT_W + 7) / 8) * 8;
  localparam int unsigned        CYCLE_LIMIT   = 1000000;
  localparam int unsigned        SETTLE_CYCLES = 8;
  localparam int unsigned        PLANNED_ITEMS = 285;
  localparam int unsigned        PHASES        = 7;
  localparam logic [MODE_W-1:0]  MODE_UNUSED   = 2'd3;
  localparam logic [WTIME_W-1:0] TIME_REG_MAX  = '1;
  localparam logic [VALUE_W-1:0] VALUE_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [47:0]        STAMP_MAX     = '1;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [CFG_W-1:0]     pwdata        = '0;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic [MODE_W-1:0]    s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  int                   mismatch_count;
  int                   pending_results;
  int                   results_checked;
  int unsigned          cycle_count    = 0;
  int unsigned          items_sent     = 0;
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  logic [TIME_BITS_DEF-1:0] stamp;

  sliding_window_slice_sampler dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  window_sample_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .mismatch_count_o(mismatch_count),
    .pending_results_o(pending_results),
    .results_checked_o(results_checked)
  );

  always #4 clk_i = ~clk_i;

  // The receiver stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hard stop on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Idle pattern follows the progress of the run.
  task automatic pick_idling();
    case (items_sent * 3 / PLANNED_ITEMS)
      0: begin
        send_idle_pct  = 34;
        recv_stall_pct = 56;
      end
      1: begin
        send_idle_pct  = 56;
        recv_stall_pct = 34;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // One input transfer; valid stays high for a following item with no gap.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                           input logic [TIME_BITS_DEF-1:0] ts, input logic [DRAW_W-1:0] draw);
    pick_idling();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {draw, ts, value};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Hold the input back until every expected result has been seen.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic configure(input logic [WENT_W-1:0] entries, input logic [WTIME_W-1:0] wtime,
                           input logic [WTIME_W-1:0] stime);
    write_reg(REG_WINDOW_ENTRIES, CFG_W'(entries));
    write_reg(REG_WINDOW_TIME, CFG_W'(wtime));
    write_reg(REG_SLICE_TIME, CFG_W'(stime));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly updates on a rising time line, with some backward steps and wild jumps.
  task automatic send_random(input int unsigned step);
    int unsigned       pick;
    int unsigned       jump;
    logic [MODE_W-1:0] mode;
    logic [63:0]       wide;
    pick = $urandom_range(0, 99);
    if (pick < 76)
      mode = MODE_UPDATE;
    else if (pick < 90)
      mode = MODE_SNAPSHOT;
    else if (pick < 95)
      mode = MODE_CLEAR;
    else
      mode = MODE_UNUSED;
    jump = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (jump < 4)
      stamp = stamp - $urandom_range(0, step * 3);
    else if (jump < 6)
      stamp = wide[TIME_BITS_DEF-1:0];
    else
      stamp = stamp + $urandom_range(0, step);
    send_item(mode, {$urandom, $urandom}, stamp, $urandom);
  endtask

  // One register setting followed by random traffic suited to it.
  task automatic run_phase(input int unsigned phase);
    logic [WENT_W-1:0]  entries;
    logic [WTIME_W-1:0] wtime;
    logic [WTIME_W-1:0] stime;
    int unsigned        count;
    int unsigned        step;
    int unsigned        i;
    logic [63:0]        wide;
    case (phase)
      1: begin
        entries = 7'd4;   wtime = 40'd1000;     stime = 40'd250;      step = 300; count = 30;
      end
      2: begin
        entries = 7'd1;   wtime = 40'd500;      stime = 40'd100;      step = 150; count = 30;
      end
      3: begin
        entries = 7'd0;   wtime = 40'd2000;     stime = 40'd200;      step = 300; count = 30;
      end
      4: begin
        entries = 7'd127; wtime = TIME_REG_MAX; stime = 40'd0;        step = 3;   count = 30;
      end
      5: begin
        entries = 7'd3;   wtime = TIME_REG_MAX; stime = 40'd0;        step = 3;   count = 30;
      end
      6: begin
        entries = 7'd64;  wtime = 40'd0;        stime = TIME_REG_MAX; step = 2;   count = 20;
      end
      default: begin
        entries = WENT_W'($urandom_range(1, 64));
        wtime   = WTIME_W'($urandom_range(64, 5000));
        stime   = wtime / entries;
        step    = 2 * int'(stime) + 1;
        count   = 30;
      end
    endcase
    configure(entries, wtime, stime);
    wide  = {$urandom, $urandom};
    stamp = {1'b0, wide[TIME_BITS_DEF-2:0]};
    for (i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_for_results();
      send_random(step);
    end
    // Fill the ring past its depth so that the next, smaller size must trim it.
    if (phase == 4) begin
      for (i = 0; i < 66; i++) begin
        stamp = stamp + 1'b1;
        send_item(MODE_UPDATE, {$urandom, $urandom}, stamp, $urandom);
      end
      send_item(MODE_SNAPSHOT, '0, stamp, '0);
    end
    wait_for_results();
  endtask

  initial begin
    int unsigned p;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset register values.
    send_item(MODE_SNAPSHOT, VALUE_MAX, 48'd0, '0);
    send_item(MODE_UPDATE, VALUE_MAX, 48'd0, 32'd0);
    send_item(MODE_UPDATE, VALUE_MIN, 48'd0, 32'd0);
    // Exactly one slice length later is still the same slice.
    send_item(MODE_UPDATE, 64'd0, 48'd937500, 32'hFFFF_FFFF);
    send_item(MODE_UPDATE, '1, 48'd937501, 32'hFFFF_FFFF);
    send_item(MODE_SNAPSHOT, '0, 48'd937501, '0);
    send_item(MODE_UNUSED, '1, STAMP_MAX, '1);
    send_item(MODE_UPDATE, 64'd5, 48'd60000001, 32'd7);
    // An older timestamp neither expires nor opens a slice.
    send_item(MODE_UPDATE, 64'd7, 48'd100, 32'd1);
    send_item(MODE_UPDATE, 64'h5555_5555_5555_5555, STAMP_MAX, 32'hAAAA_AAAA);
    send_item(MODE_SNAPSHOT, '0, STAMP_MAX, '0);
    send_item(MODE_CLEAR, '1, '0, '1);
    send_item(MODE_SNAPSHOT, '0, '0, '0);
    send_item(MODE_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, STAMP_MAX, 32'd0);
    send_item(MODE_UPDATE, 64'd11, STAMP_MAX, 32'd1);
    // Draw times counter right at, then just above, the replacement bound.
    send_item(MODE_UPDATE, 64'd12, STAMP_MAX, 32'h5555_5555);
    send_item(MODE_UPDATE, 64'd13, STAMP_MAX, 32'h4000_0000);
    send_item(MODE_SNAPSHOT, '0, STAMP_MAX, '0);
    wait_for_results();

    for (p = 1; p <= PHASES; p++)
      run_phase(p);

    wait_for_results();
    $display("Checked %0d results from %0d input transfers over eight register settings,",
             results_checked, items_sent);
    $display("with expiry, slice replacement, ring overflow, trimming, clears and idle gaps.");
    if (mismatch_count == 0 && pending_results == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
